// ===== rtl/hll_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the HyperLogLog register sketch.
package hll_pkg;

	// Field widths fixed by the block's interface.
	localparam int IDX_W  = 16;
	localparam int RANK_W = 6;
	localparam int ZERO_W = 17;
	localparam int SUM_W  = 64;
	localparam int HASH_W = 64;

	// Fixed point format of the harmonic sum and the range of the size register.
	localparam int FRACTION_BITS = 47;
	localparam int MIN_LOG2M     = 4;
	localparam int RESET_LOG2M   = 10;

	// Action codes.
	localparam logic [1:0] ACT_OFFER = 2'd0;
	localparam logic [1:0] ACT_MERGE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// Register indexes on the configuration port.
	localparam logic REG_LOG2M     = 1'b0;
	localparam logic REG_HASH_MODE = 1'b1;

	// One input beat.
	typedef struct packed {
		logic [1:0]        action;
		logic [HASH_W-1:0] hash_value;
		logic [IDX_W-1:0]  reg_index;
		logic [RANK_W-1:0] reg_value;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic              changed;
		logic              status;
		logic [RANK_W-1:0] register_value;
		logic [ZERO_W-1:0] zero_count;
		logic [SUM_W-1:0]  harmonic_sum;
	} result_t;

	// Decoded item handed from the lookup stage to the update stage.
	typedef struct packed {
		logic [1:0]        action;
		logic [IDX_W-1:0]  addr;
		logic [RANK_W-1:0] rank;
		logic              out_of_range;
	} lookup_t;

	// Contribution 2^-rank of one register in fixed point; very large ranks add nothing.
	function automatic logic [SUM_W-1:0] rank_weight(input logic [RANK_W-1:0] rank);
		logic [SUM_W-1:0] w;
		w = '0;
		if (rank <= RANK_W'(FRACTION_BITS)) begin
			w = SUM_W'(1) << (RANK_W'(FRACTION_BITS) - rank);
		end
		return w;
	endfunction

	// Number of registers in use for a given size setting.
	function automatic logic [ZERO_W-1:0] zero_of_size(input logic [4:0] log2m);
		return ZERO_W'(1) << log2m;
	endfunction

	// Harmonic sum of an empty store of the given size.
	function automatic logic [SUM_W-1:0] sum_of_size(input logic [4:0] log2m);
		return SUM_W'(zero_of_size(log2m)) << FRACTION_BITS;
	endfunction

endpackage

// ===== rtl/hyperloglog_register_sketch_core.sv =====
`timescale 1ns / 1ps
// HyperLogLog register sketch: top level with update stage, totals, clearing walk and APB port.
//
// Offers, merges and reads each take one beat and can follow one another in every cycle while the
// result channel does not stall: the item's register is read from the rank memory at acceptance,
// and when the update stage fires it is raised, written back and the result is loaded into the
// output register. Back-to-back items that touch the same register see the last written value
// through a forwarding register. A clear, and a write of log2m, walk the single write port of the
// rank memory over 2^log2m entries, one per cycle, while no item is accepted; after reset the same
// clearing pass runs over 2^10 = 1024 entries (fewer if MAX_LOG2M is smaller) before the first
// item is taken. The clear's own result is delivered at the start of its walk.
module hyperloglog_register_sketch_core #(
	parameter int MAX_LOG2M = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// Input channel
	input  logic              item_valid,
	output logic              item_stall,
	input  hll_pkg::item_t    item,
	// Result channel
	output logic              result_valid,
	input  logic              result_stall,
	output hll_pkg::result_t  result
);
	import hll_pkg::*;

	localparam int          ADDR_W    = MAX_LOG2M;
	localparam logic [4:0]  RESET_L2M =
		5'((RESET_LOG2M > MAX_LOG2M) ? MAX_LOG2M : RESET_LOG2M);

	// Configuration and control state
	logic [4:0]        log2m_q;
	logic              hash64_q;
	logic              walking_q;
	logic [ADDR_W-1:0] walk_cnt_q;

	// Update stage
	logic              s1_valid_q;
	lookup_t           s1_q;

	// Running totals
	logic [ZERO_W-1:0] zero_q;
	logic [SUM_W-1:0]  sum_q;

	// Last write, forwarded to the next item
	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [RANK_W-1:0] fwd_val_q;

	// Output register
	logic              out_valid_q;
	result_t           out_q;

	// Combinational signals
	lookup_t           lookup;
	logic              cfg_write;
	logic              log2m_write;
	logic              mode_write;
	logic [4:0]        log2m_new;
	logic [ZERO_W-1:0] size;
	logic              walk_last;
	logic              accept;
	logic              s1_fire;
	logic              s1_clear;
	logic [ADDR_W-1:0] s1_addr;
	logic [RANK_W-1:0] mem_rd_data;
	logic [RANK_W-1:0] old_rank;
	logic              raise;
	logic [RANK_W-1:0] new_rank;
	logic [ZERO_W-1:0] zero_next;
	logic [SUM_W-1:0]  sum_next;
	logic [RANK_W-1:0] reg_out;
	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [RANK_W-1:0] mem_wr_data;

	// Configuration port decode; pready is always high.
	assign pready      = 1'b1;
	assign cfg_write   = psel && penable && pwrite && pready;
	assign log2m_write = cfg_write && (paddr[2] == REG_LOG2M);
	assign mode_write  = cfg_write && (paddr[2] == REG_HASH_MODE);

	// Size writes are clamped into the supported range.
	always_comb begin
		log2m_new = pwdata[4:0];
		if (log2m_new < 5'(MIN_LOG2M)) begin
			log2m_new = 5'(MIN_LOG2M);
		end
		if (log2m_new > 5'(MAX_LOG2M)) begin
			log2m_new = 5'(MAX_LOG2M);
		end
	end

	// Register readback.
	always_comb begin
		if (paddr[2] == REG_LOG2M) begin
			prdata = {27'b0, log2m_q};
		end else begin
			prdata = {31'b0, hash64_q};
		end
	end

	// Lookup stage.
	hll_decode u_decode (
		.item    (item),
		.log2m   (log2m_q),
		.hash_64 (hash64_q),
		.lookup  (lookup)
	);

	// Handshake: the update stage moves on when the output register is free or being emptied.
	assign size       = zero_of_size(log2m_q);
	assign walk_last  = (ZERO_W'(walk_cnt_q) == (size - ZERO_W'(1)));
	assign s1_fire    = s1_valid_q && (!out_valid_q || !result_stall);
	assign s1_clear   = (s1_q.action == ACT_CLEAR);
	assign item_stall = walking_q || (s1_valid_q && (s1_clear || !s1_fire));
	assign accept     = item_valid && !item_stall;
	assign s1_addr    = s1_q.addr[ADDR_W-1:0];

	// Rank memory.
	hll_rank_mem #(
		.ADDR_W (ADDR_W)
	) u_rank_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (lookup.addr[ADDR_W-1:0]),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// Read-modify-write of the addressed register and update of the totals.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
			old_rank = fwd_val_q;
		end else begin
			old_rank = mem_rd_data;
		end
		raise     = ((s1_q.action == ACT_OFFER) || (s1_q.action == ACT_MERGE))
			&& !s1_q.out_of_range && (s1_q.rank > old_rank);
		new_rank  = raise ? s1_q.rank : old_rank;
		zero_next = zero_q;
		sum_next  = sum_q;
		reg_out   = '0;
		if (s1_clear) begin
			zero_next = size;
			sum_next  = sum_of_size(log2m_q);
		end else begin
			if (raise) begin
				if (old_rank == '0) begin
					zero_next = zero_q - ZERO_W'(1);
				end
				sum_next = sum_q - rank_weight(old_rank) + rank_weight(s1_q.rank);
			end
			if (!s1_q.out_of_range) begin
				reg_out = new_rank;
			end
		end
	end

	// Write port: the clearing walk owns it while running.
	always_comb begin
		if (walking_q) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = walk_cnt_q;
			mem_wr_data = '0;
		end else begin
			mem_wr_en   = s1_fire && raise;
			mem_wr_addr = s1_addr;
			mem_wr_data = s1_q.rank;
		end
	end

	// Configuration registers, clearing walk and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2m_q    <= RESET_L2M;
			hash64_q   <= 1'b0;
			walking_q  <= 1'b1;
			walk_cnt_q <= '0;
			zero_q     <= zero_of_size(RESET_L2M);
			sum_q      <= sum_of_size(RESET_L2M);
		end else begin
			if (mode_write) begin
				hash64_q <= pwdata[0];
			end
			if (log2m_write) begin
				log2m_q    <= log2m_new;
				walking_q  <= 1'b1;
				walk_cnt_q <= '0;
				zero_q     <= zero_of_size(log2m_new);
				sum_q      <= sum_of_size(log2m_new);
			end else if (walking_q) begin
				if (walk_last) begin
					walking_q <= 1'b0;
				end else begin
					walk_cnt_q <= walk_cnt_q + ADDR_W'(1);
				end
			end else if (s1_fire) begin
				zero_q <= zero_next;
				sum_q  <= sum_next;
				if (s1_clear) begin
					walking_q  <= 1'b1;
					walk_cnt_q <= '0;
				end
			end
		end
	end

	// Update stage occupancy and forwarding of the last write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (log2m_write || (s1_fire && s1_clear)) begin
				fwd_valid_q <= 1'b0;
			end else if (s1_fire && raise) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	// Payload of the update stage and the forwarding register.
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= lookup;
		end
		if (s1_fire && raise) begin
			fwd_addr_q <= s1_addr;
			fwd_val_q  <= s1_q.rank;
		end
	end

	// Output register: one result beat per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q.changed        <= raise;
			out_q.status         <= s1_q.out_of_range;
			out_q.register_value <= reg_out;
			out_q.zero_count     <= zero_next;
			out_q.harmonic_sum   <= sum_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/hll_decode.sv =====
`timescale 1ns / 1ps
// Lookup stage: works out the register address, the rank and the range check of an item.
module hll_decode (
	input  hll_pkg::item_t   item,
	input  logic [4:0]       log2m,
	input  logic             hash_64,
	output hll_pkg::lookup_t lookup
);
	import hll_pkg::*;

	logic [6:0]        hash_len;
	logic [6:0]        low_width;
	logic [HASH_W-1:0] hash_x;
	logic [HASH_W-1:0] hash_top;
	logic [6:0]        tz;
	logic [6:0]        rank_full;
	logic [ZERO_W-1:0] size;

	// Trailing zero count of a 64-bit word; an all-zero word gives 64.
	function automatic logic [6:0] trailing_zeros(input logic [HASH_W-1:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = HASH_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = 7'(i);
			end
		end
		return n;
	endfunction

	// The top log2m bits of the hash pick the register; the rest give the rank.
	always_comb begin
		hash_len  = hash_64 ? 7'd64 : 7'd32;
		low_width = hash_len - {2'b00, log2m};
		hash_x    = hash_64 ? item.hash_value : {32'b0, item.hash_value[31:0]};
		hash_top  = hash_x >> low_width;
		tz        = trailing_zeros(hash_x);
		// Zeros beyond the low part count as an all-zero low part.
		rank_full = ((tz < low_width) ? tz : low_width) + 7'd1;
		size      = zero_of_size(log2m);
	end

	// Per-action selection of address, rank and range check.
	always_comb begin
		lookup.action       = item.action;
		lookup.addr         = '0;
		lookup.rank         = '0;
		lookup.out_of_range = 1'b0;
		case (item.action)
			ACT_OFFER: begin
				lookup.addr = hash_top[IDX_W-1:0];
				lookup.rank = rank_full[RANK_W-1:0];
			end
			ACT_MERGE, ACT_READ: begin
				lookup.addr         = item.reg_index;
				lookup.rank         = item.reg_value;
				lookup.out_of_range = ({1'b0, item.reg_index} >= size);
			end
			default: begin
				lookup.addr = '0;
			end
		endcase
	end

endmodule

// ===== rtl/hll_rank_mem.sv =====
`timescale 1ns / 1ps
// Rank store: synchronous memory with one write port and one registered read port.
module hll_rank_mem #(
	parameter int ADDR_W = 16
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [hll_pkg::RANK_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [hll_pkg::RANK_W-1:0] wr_data
);
	import hll_pkg::*;

	logic [RANK_W-1:0] mem [2**ADDR_W];
	logic [RANK_W-1:0] rd_data_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
